>>> rtl/core/short_string_hash_set_unit_macros.svh
// assertion macros used by the checker file
`ifndef SHORT_STRING_HASH_SET_UNIT_MACROS_SVH
`define SHORT_STRING_HASH_SET_UNIT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define SSHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define SSHS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sshs_pkg.sv
// shared types and constants of the short string hash set
package sshs_pkg;

  localparam int MAX_WORD_BYTES = 30;
  localparam int LEN_W          = 5;
  localparam int HASH_W         = 32;
  localparam int COUNT_W        = 11;
  localparam int CFG_W          = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef logic [MAX_WORD_BYTES-1:0][7:0] word_t;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  word_length;
    logic [63:0] word_bytes_a;
    logic [63:0] word_bytes_b;
    logic [63:0] word_bytes_c;
    logic [47:0] word_bytes_d;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HASH_W-1:0] hash;
    word_t             bytes;
  } slot_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] hash;
  } crc_stat_t;

endpackage

>>> rtl/core/sshs_ram.sv
// generic single write, single read ram with registered read data
module sshs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/sshs_crc.sv
// byte serial crc-32c engine, one byte per cycle
module sshs_crc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  sshs_pkg::word_t                      word,
  input  logic [sshs_pkg::LEN_W-1:0]           len,
  output sshs_pkg::crc_stat_t                  stat
);
  import sshs_pkg::*;

  localparam logic [31:0] POLY = 32'h82F6_3B78;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ POLY) : (x >> 1);
    end
    return x;
  endfunction

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [31:0]       step;

  assign step = crc_byte(crc_r, word[cnt_r]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    hash_nxt = hash_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      crc_nxt  = '1;
    end else if (busy_r) begin
      crc_nxt = step;
      if (cnt_r == len - LEN_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        hash_nxt = ~step;
      end else begin
        cnt_nxt = cnt_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    crc_r  <= crc_nxt;
    hash_r <= hash_nxt;
  end

  assign stat.done = done_r;
  assign stat.hash = hash_r;

endmodule

>>> rtl/core/short_string_hash_set_unit.sv
// top level of the short string hash set: control, probe sequencer and slot ram
// A set of words of 1 to 30 bytes held in an open addressed table of SLOTS
// slots with linear probing. Each transfer on the in_ channel is an insert
// or a lookup; each gives exactly one transfer on the out_ channel with
// found, a status and the number of stored words. After reset the block
// runs a clearing pass over every slot of the slot ram and holds in_stall
// high meanwhile. The crc-32c engine then hashes one byte a cycle, and
// each probe is a read of the slot ram followed by a compare state, since
// the ram read data is registered. A bad length skips hashing and probing.
// One item is worked on at a time; a new one is taken while a finished
// result still waits in the output register. The user is to write size_log2
// on the cfg_ channel only while the block is idle; the block itself does
// not enforce it. Probes use the table slice it selects.
module short_string_hash_set_unit #(
  parameter int SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sshs_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sshs_pkg::result_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sshs_pkg::CFG_W-1:0]    cfg_data
);
  import sshs_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int EW = $bits(slot_t);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   size_log2_r, size_log2_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;

  // current item
  logic               req_r, req_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  word_t              word_r, word_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [NW-1:0]      probe_r, probe_nxt;
  logic               found_r, found_nxt;
  logic [1:0]         status_r, status_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  result_t            out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               out_free;
  logic               bad_len;
  logic [239:0]       raw_bytes;
  word_t              in_word;

  logic [CFG_W-1:0]   size_eff;
  logic [16:0]        pow_full;
  logic [NW-1:0]      n_slots;
  logic [AW-1:0]      mask;
  logic [AW-1:0]      idx_raw;
  logic [AW-1:0]      idx;

  crc_stat_t          crc_stat;
  logic               crc_start;

  slot_t              rd_slot;
  logic [EW-1:0]      rd_bits;
  slot_t              wr_slot;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic               slot_empty;
  logic               slot_match;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // bytes at or past the length read as zero, as they are stored
  assign raw_bytes = {in_data.word_bytes_d, in_data.word_bytes_c,
                      in_data.word_bytes_b, in_data.word_bytes_a};
  always_comb begin
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      in_word[i] = (LEN_W'(i) < in_data.word_length) ? raw_bytes[i*8 +: 8] : 8'd0;
    end
  end
  assign bad_len = (in_data.word_length == '0) ||
                   (in_data.word_length > LEN_W'(MAX_WORD_BYTES));

  // slots in use: 2^size_log2 with zero counted as one, capped at SLOTS
  assign size_eff = (size_log2_r == '0) ? CFG_W'(1) : size_log2_r;
  assign pow_full = 17'(1) << size_eff;
  assign n_slots  = ({15'd0, pow_full} > 32'(SLOTS)) ? NW'(SLOTS) : NW'(pow_full);
  assign mask     = AW'(n_slots - NW'(1));

  // probe address, folded to slot zero past the end of a non power of two table
  assign idx_raw = pos_r & mask;
  assign idx     = ({1'b0, idx_raw} >= (AW+1)'(SLOTS)) ? '0 : idx_raw;

  assign crc_start = in_xfer && !bad_len;

  sshs_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (crc_start),
    .word  (word_r),
    .len   (len_r),
    .stat  (crc_stat)
  );

  assign rd_slot    = slot_t'(rd_bits);
  assign slot_empty = (rd_slot.len == '0);
  assign slot_match = (rd_slot.hash == hash_r) && (rd_slot.len == len_r) &&
                      (rd_slot.bytes == word_r);

  assign rd_en = (state_r == S_PROBE);

  // clearing pass writes empty slots, an insert writes the probed slot
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_slot.len   = len_r;
    wr_slot.hash  = hash_r;
    wr_slot.bytes = word_r;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_slot = '0;
    end else if (state_r == S_CHECK && slot_empty && req_r == REQ_INSERT) begin
      wr_en = 1'b1;
    end
  end

  sshs_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (EW'(wr_slot)),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_bits)
  );

  always_comb begin
    state_nxt     = state_r;
    size_log2_nxt = size_log2_r;
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    len_nxt       = len_r;
    word_nxt      = word_r;
    hash_nxt      = hash_r;
    pos_nxt       = pos_r;
    probe_nxt     = probe_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      size_log2_nxt = cfg_data;
    end

    // output register drains on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt    = in_data.req_type;
          len_nxt    = in_data.word_length;
          word_nxt   = in_word;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          if (bad_len) begin
            status_nxt = ST_BAD_LEN;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (crc_stat.done) begin
          hash_nxt  = crc_stat.hash;
          pos_nxt   = crc_stat.hash[AW-1:0] & mask;
          probe_nxt = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (slot_empty) begin
          if (req_r == REQ_INSERT) begin
            count_nxt = count_r + COUNT_W'(1);
          end
          state_nxt = S_DONE;
        end else if (slot_match) begin
          found_nxt = (req_r == REQ_LOOKUP);
          state_nxt = S_DONE;
        end else if (probe_r + NW'(1) == n_slots) begin
          // every slot in use visited without a hit or a hole
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          pos_nxt   = pos_r + AW'(1);
          probe_nxt = probe_r + NW'(1);
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = found_r;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = count_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      size_log2_r <= CFG_W'(10);
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_log2_r <= size_log2_nxt;
      count_r     <= count_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    len_r      <= len_nxt;
    word_r     <= word_nxt;
    hash_r     <= hash_nxt;
    pos_r      <= pos_nxt;
    probe_r    <= probe_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/core/sshs_checker.sv
// port level checker for the short string hash set, bound to the top level
`include "short_string_hash_set_unit_macros.svh"

module sshs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input sshs_pkg::result_t    out_data
);
  import sshs_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // items taken but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SSHS_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && in_stall, "no result or intake right after reset")
  `SSHS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `SSHS_ASSERT(a_found_ok, out_valid && out_data.status != ST_OK |-> !out_data.found, "found set with error status")
  `SSHS_ASSERT(a_no_extra, out_xfer |-> pend_r != 2'd0, "result without a pending item")

endmodule

bind short_string_hash_set_unit sshs_checker u_sshs_checker (.*);
